// ----- rtl/rdp_pkg.sv -----
// rdp_pkg: shared constants, field widths and the sequencer state type
// for the deduplicating palette store. No dependencies.
`timescale 1ns / 1ps
package rdp_pkg;
	localparam int TYPE_W = 16;
	localparam int POS_W  = 12;
	localparam int SLOT_W = 12;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CELL_RD,
		ST_CELL_CHK,
		ST_OLD_CHK,
		ST_REL,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_ALLOC,
		ST_OUT_RD,
		ST_OUT_CHK,
		ST_OUT
	} state_t;
endpackage

// ----- rtl/rdp_stream_if.sv -----
// rdp_stream_if: valid/ready channel with a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface rdp_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/rdp_ram.sv -----
// rdp_ram: single-port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module rdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- rtl/refcounted_dedup_palette.sv -----
// refcounted_dedup_palette: top level, sequencer around the cell map and
// palette memories. Depends on rdp_pkg, rdp_stream_if, rdp_ram.
//
// channel  dir  fields
// in_ch    in   operation, position, type_id, user_data
// out_ch   out  cell_type, cell_data, slot, occupied, changed
//
// A read of an empty cell skips the slot readback. A write scans the palette
// slots below slots_used, one slot memory read then compare per slot, so
// the scan over slots_used entries dominates the time a write takes.
// After reset the cell map is cleared, one entry a cycle, before the first
// item is accepted. One item at a time; the result is held in an output
// register until taken.
`timescale 1ns / 1ps
module refcounted_dedup_palette #(
	parameter int CELLS         = 4096,
	parameter int PALETTE_DEPTH = 4096,
	parameter int DATA_BITS     = 32
) (
	input  logic clk,
	input  logic arst_n,
	rdp_stream_if.sink   in_ch,
	rdp_stream_if.source out_ch
);
	import rdp_pkg::*;

	localparam int CA = $clog2(CELLS);
	localparam int PA = $clog2(PALETTE_DEPTH);
	localparam int PC = PA + 1;
	localparam int SW = TYPE_W + DATA_BITS + PC + PC + 1;

	state_t st_q, st_d;

	logic [CA:0]          clr_q;
	logic                 op_q;
	logic [CA-1:0]        pos_q;
	logic [TYPE_W-1:0]    typ_q;
	logic [DATA_BITS-1:0] dat_q;
	logic                 chg_q;
	logic [PA-1:0]        old_q, new_q;
	logic [PC-1:0]        idx_q;
	logic [PC-1:0]        used_q, fhead_q;
	logic                 fvalid_q;

	// cell map
	logic          c_we;
	logic [CA-1:0] c_addr;
	logic [PA:0]   c_wd, c_rd;
	// slot record: type, data, refcount, next link, next valid
	logic          s_we;
	logic [PA-1:0] s_addr;
	logic [SW-1:0] s_wd, s_rd;

	rdp_ram #(.WIDTH(PA + 1), .DEPTH(CELLS)) u_cell (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
	rdp_ram #(.WIDTH(SW), .DEPTH(PALETTE_DEPTH)) u_slot (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

	logic [TYPE_W-1:0]    r_type;
	logic [DATA_BITS-1:0] r_data;
	logic [PC-1:0]        r_cnt, r_next;
	logic                 r_nv;
	assign {r_type, r_data, r_cnt, r_next, r_nv} = s_rd;

	logic [POS_W-1:0] in_pos;
	assign in_pos = in_ch.payload.position;

	logic match;
	assign match = (r_cnt != '0) && (r_type == typ_q) && (r_data == dat_q);

	// fresh marks an allocation from the free list or by append
	logic was_fresh;
	logic fresh_q;
	assign was_fresh = fresh_q;

	// output fields valid when reached through the slot readback
	logic o_occ_valid_q;

	logic out_v_q;
	logic [TYPE_W-1:0]    o_type_q;
	logic [DATA_BITS-1:0] o_data_q;
	logic [SLOT_W-1:0]    o_slot_q;
	logic                 o_occ_q;

	assign in_ch.ready = (st_q == ST_IDLE) && clr_q[CA] && !out_v_q;
	assign out_ch.valid = out_v_q;
	always_comb begin
		out_ch.payload.cell_type = o_type_q;
		out_ch.payload.cell_data = 32'(o_data_q);
		out_ch.payload.slot      = o_slot_q;
		out_ch.payload.occupied  = o_occ_q;
		out_ch.payload.changed   = chg_q;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:     if (in_ch.valid && in_ch.ready) st_d = ST_CELL_RD;
			ST_CELL_RD:  st_d = ST_CELL_CHK;
			ST_CELL_CHK: begin
				if (!op_q)
					st_d = c_rd[PA] ? ST_OUT_CHK : ST_OUT;
				else if (c_rd[PA])
					st_d = ST_OLD_CHK;
				else if (typ_q == '0)
					st_d = ST_OUT;
				else
					st_d = ST_SCAN;
			end
			ST_OLD_CHK: begin
				if ((r_type == typ_q) && (r_data == dat_q))
					st_d = ST_OUT_CHK;
				else
					st_d = ST_REL;
			end
			ST_REL:      st_d = (typ_q == '0) ? ST_OUT : ST_SCAN;
			ST_SCAN:     st_d = (idx_q < used_q) ? ST_SCAN_CHK : ST_FREE_RD;
			ST_SCAN_CHK: st_d = match ? ST_ALLOC : ST_SCAN;
			ST_FREE_RD: begin
				if (fvalid_q && fhead_q < PC'(PALETTE_DEPTH))
					st_d = ST_FREE_CHK;
				else if (used_q < PC'(PALETTE_DEPTH))
					st_d = ST_ALLOC;
				else
					st_d = ST_OUT;
			end
			ST_FREE_CHK: st_d = ST_ALLOC;
			ST_ALLOC:    st_d = ST_OUT_RD;
			ST_OUT_RD:   st_d = ST_OUT_CHK;
			ST_OUT_CHK:  st_d = ST_OUT;
			ST_OUT:      st_d = ST_IDLE;
			default:     st_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		c_we = 1'b0; c_addr = pos_q; c_wd = '0;
		s_we = 1'b0; s_addr = old_q; s_wd = s_rd;
		case (st_q)
			ST_IDLE: begin
				if (!clr_q[CA]) begin
					c_we = 1'b1; c_addr = clr_q[CA-1:0];
				end
			end
			ST_CELL_CHK: s_addr = c_rd[PA-1:0];
			ST_OLD_CHK: begin
				// same-contents miss: drop the cell mapping
				if (!((r_type == typ_q) && (r_data == dat_q)))
					c_we = 1'b1;
			end
			ST_REL: begin
				if (r_cnt != '0) begin
					s_we = 1'b1;
					if (r_cnt == PC'(1))
						s_wd = {r_type, r_data, {PC{1'b0}}, fhead_q, fvalid_q};
					else
						s_wd = {r_type, r_data, r_cnt - PC'(1), r_next, r_nv};
				end
			end
			ST_SCAN:     s_addr = idx_q[PA-1:0];
			ST_SCAN_CHK: s_addr = idx_q[PA-1:0];
			ST_FREE_RD:  s_addr = fhead_q[PA-1:0];
			ST_FREE_CHK: s_addr = fhead_q[PA-1:0];
			ST_ALLOC: begin
				s_addr = new_q; s_we = 1'b1;
				if (match && !was_fresh)
					s_wd = {r_type, r_data, r_cnt + PC'(1), r_next, r_nv};
				else
					s_wd = {typ_q, dat_q, PC'(1), r_next, r_nv};
				c_we = 1'b1; c_wd = {1'b1, new_q};
			end
			ST_OUT_RD:  s_addr = new_q;
			ST_OUT_CHK: s_addr = new_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			clr_q <= '0;
			out_v_q <= 1'b0;
			used_q <= '0;
			fvalid_q <= 1'b0;
			fhead_q <= '0;
		end else begin
			st_q <= st_d;
			if (!clr_q[CA])
				clr_q <= clr_q + 1'b1;
			if (st_q == ST_OUT)
				out_v_q <= 1'b1;
			else if (out_ch.ready)
				out_v_q <= 1'b0;
			if (st_q == ST_REL && r_cnt == PC'(1)) begin
				fhead_q <= {1'b0, old_q}; fvalid_q <= 1'b1;
			end
			if (st_q == ST_FREE_CHK) begin
				fhead_q <= r_next; fvalid_q <= r_nv;
			end
			if (st_q == ST_FREE_RD && st_d == ST_ALLOC)
				used_q <= used_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				// load only on a transfer so a waiting result keeps its flags
				if (in_ch.valid && in_ch.ready) begin
					op_q <= in_ch.payload.operation;
					pos_q <= CA'(in_pos);
					typ_q <= in_ch.payload.type_id;
					dat_q <= in_ch.payload.user_data[DATA_BITS-1:0];
					chg_q <= 1'b0;
					fresh_q <= 1'b0;
					idx_q <= '0;
				end
			end
			ST_CELL_CHK: begin
				old_q <= c_rd[PA-1:0];
				new_q <= c_rd[PA-1:0];
			end
			ST_REL: chg_q <= 1'b1;
			ST_SCAN_CHK: begin
				if (match) begin
					new_q <= idx_q[PA-1:0]; chg_q <= 1'b1;
				end else
					idx_q <= idx_q + 1'b1;
			end
			ST_FREE_RD: begin
				fresh_q <= 1'b1;
				if (fvalid_q && fhead_q < PC'(PALETTE_DEPTH))
					new_q <= fhead_q[PA-1:0];
				else
					new_q <= used_q[PA-1:0];
			end
			ST_ALLOC: chg_q <= 1'b1;
			ST_OUT_CHK: begin
				o_type_q <= r_type; o_data_q <= r_data;
				o_slot_q <= SLOT_W'(new_q); o_occ_q <= 1'b1;
			end
			ST_OUT: begin
				if (!(st_q == ST_OUT && o_occ_valid_q)) begin
					o_type_q <= '0; o_data_q <= '0;
					o_slot_q <= '0; o_occ_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_occ_valid_q <= 1'b0;
		else if (st_q == ST_OUT_CHK)
			o_occ_valid_q <= 1'b1;
		else if (st_q == ST_OUT)
			o_occ_valid_q <= 1'b0;
	end
endmodule

// ----- sim/refcounted_dedup_palette_test.sv -----
// refcounted_dedup_palette_test: self-checking bench for the palette store.
// Keeps its own copy of the cell map, slots and free list, predicts each result.
// Depends on rdp_pkg, rdp_stream_if and the refcounted_dedup_palette RTL.
`timescale 1ns / 1ps
module refcounted_dedup_palette_test;
	import rdp_pkg::*;

	localparam int CELLS      = 4096;
	localparam int DEPTH      = 4096;
	localparam int IDLE_LIMIT = 60000;

	typedef enum logic { OP_READ = 1'b0, OP_WRITE = 1'b1 } op_e;

	typedef struct packed {
		logic              operation;
		logic [POS_W-1:0]  position;
		logic [TYPE_W-1:0] type_id;
		logic [31:0]       user_data;
	} cmd_t;

	typedef struct packed {
		logic [TYPE_W-1:0] cell_type;
		logic [31:0]       cell_data;
		logic [SLOT_W-1:0] slot;
		logic              occupied;
		logic              changed;
	} cell_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rdp_stream_if #(.payload_t(cmd_t))      cmd_ch ();
	rdp_stream_if #(.payload_t(cell_rsp_t)) rsp_ch ();

	refcounted_dedup_palette uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_ch),
		.out_ch (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirror of the block's state
	bit              m_cell_valid [CELLS];
	int unsigned     m_cell_slot  [CELLS];
	logic [15:0]     m_slot_type  [DEPTH];
	logic [31:0]     m_slot_data  [DEPTH];
	int unsigned     m_slot_refs  [DEPTH];
	int unsigned     m_slot_link  [DEPTH];
	bit              m_link_valid [DEPTH];
	int unsigned     m_free_head;
	bit              m_free_valid;
	int unsigned     m_slots_used;

	cell_rsp_t pending_cells [$];
	int        errors = 0;
	bit        calm = 1'b0;
	bit        hold_req = 1'b0;
	int        hold_left = 0;

	function automatic void drop_slot(int unsigned s);
		if (m_slot_refs[s] == 0)
			return;
		m_slot_refs[s]--;
		if (m_slot_refs[s] == 0) begin
			m_slot_link[s]  = m_free_head;
			m_link_valid[s] = m_free_valid;
			m_free_head     = s;
			m_free_valid    = 1'b1;
		end
	endfunction

	function automatic bit find_slot(logic [15:0] t, logic [31:0] d, output int unsigned s);
		int unsigned i;
		for (i = 0; i < m_slots_used; i++) begin
			if (m_slot_refs[i] != 0 && m_slot_type[i] == t && m_slot_data[i] == d) begin
				s = i;
				return 1'b1;
			end
		end
		if (m_free_valid) begin
			i = m_free_head;
			m_free_head  = m_slot_link[i];
			m_free_valid = m_link_valid[i];
		end else if (m_slots_used < DEPTH) begin
			i = m_slots_used;
			m_slots_used++;
		end else begin
			return 1'b0;
		end
		m_slot_type[i] = t;
		m_slot_data[i] = d;
		m_slot_refs[i] = 0;
		s = i;
		return 1'b1;
	endfunction

	function automatic cell_rsp_t predict_cell(cmd_t c);
		cell_rsp_t r;
		int unsigned p, s;
		bit was, same;
		p = c.position;
		r = '0;
		if (c.operation == OP_WRITE) begin
			was = m_cell_valid[p];
			if (was) begin
				s = m_cell_slot[p];
				same = (m_slot_type[s] == c.type_id && m_slot_data[s] == c.user_data);
				if (!same) begin
					m_cell_valid[p] = 1'b0;
					drop_slot(s);
				end
			end else begin
				same = (c.type_id == 0);
			end
			if (!same) begin
				if (c.type_id != 0 && find_slot(c.type_id, c.user_data, s)) begin
					m_cell_slot[p]  = s;
					m_cell_valid[p] = 1'b1;
					m_slot_refs[s]++;
				end
				r.changed = was || m_cell_valid[p];
			end
		end
		if (m_cell_valid[p]) begin
			s = m_cell_slot[p];
			r.cell_type = m_slot_type[s];
			r.cell_data = m_slot_data[s];
			r.slot      = s[SLOT_W-1:0];
			r.occupied  = 1'b1;
		end
		return r;
	endfunction

	// one transfer on the command channel; valid stays high between back-to-back items unless a random gap is put in
	task automatic send_cmd(op_e op, int unsigned pos, int unsigned t, int unsigned d);
		cmd_t c;
		c.operation = op;
		c.position  = pos[POS_W-1:0];
		c.type_id   = t[TYPE_W-1:0];
		c.user_data = d;
		if (!calm && $urandom_range(99) < 28) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_cells.insert(pending_cells.size(), predict_cell(c));
	endtask

	task automatic drain_cells();
		cmd_ch.valid <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_cmd(OP_READ, 0, 0, 0);
		send_cmd(OP_WRITE, 4095, 0, 0);
		send_cmd(OP_WRITE, 0, 16'hffff, 32'hffffffff);
		send_cmd(OP_WRITE, 0, 16'hffff, 32'hffffffff);
		send_cmd(OP_WRITE, 4095, 1, 0);
		send_cmd(OP_READ, 4095, 16'hffff, 32'hffffffff);
		send_cmd(OP_WRITE, 1, 16'hffff, 32'hffffffff);
		send_cmd(OP_READ, 0, 0, 0);
	endtask

	task automatic test_free_list();
		// release slot 0 and slot 1 then refill; slot 0 must come back
		send_cmd(OP_WRITE, 0, 0, 0);
		send_cmd(OP_WRITE, 1, 0, 0);
		send_cmd(OP_WRITE, 4095, 0, 32'h5);
		send_cmd(OP_READ, 1, 0, 0);
		send_cmd(OP_WRITE, 2, 16'h1234, 32'hdeadbeef);
		send_cmd(OP_WRITE, 3, 16'h1234, 32'hdeadbeef);
		send_cmd(OP_WRITE, 4, 16'h4321, 32'h0);
		send_cmd(OP_WRITE, 5, 16'h4321, 32'h0);
		send_cmd(OP_WRITE, 2, 16'h4321, 32'h0);
		send_cmd(OP_WRITE, 3, 16'h8000, 32'h80000000);
		send_cmd(OP_WRITE, 6, 16'h1234, 32'hdeadbeef);
		send_cmd(OP_READ, 3, 0, 0);
		send_cmd(OP_READ, 6, 0, 0);
		drain_cells();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		calm = 1'b1;
		repeat (6) send_cmd(OP_WRITE, $urandom_range(7), $urandom_range(3), $urandom_range(3));
		calm = 1'b0;
		drain_cells();
	endtask

	task automatic test_random(int n);
		int unsigned op, pos, t, d;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 2);
			op  = ($urandom_range(99) < 75) ? OP_WRITE : OP_READ;
			pos = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(15);
			if ($urandom_range(6) == 0) begin
				t = $urandom_range(16'hffff);
				d = $urandom();
			end else begin
				t = $urandom_range(3);
				d = $urandom_range(2);
			end
			send_cmd(op_e'(op), pos, t, d);
		end
		calm = 1'b0;
	endtask

	// result side: ready pattern and the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 28);
			end
		end
	end

	always @(posedge clk) begin
		cell_rsp_t want, got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (pending_cells.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_cells.pop_front();
				if (got.cell_type !== want.cell_type) begin
					$display("%0t: cell_type exp %h got %h", $time, want.cell_type, got.cell_type);
					errors++;
				end
				if (got.cell_data !== want.cell_data) begin
					$display("%0t: cell_data exp %h got %h", $time, want.cell_data, got.cell_data);
					errors++;
				end
				if (got.slot !== want.slot) begin
					$display("%0t: slot exp %h got %h", $time, want.slot, got.slot);
					errors++;
				end
				if (got.occupied !== want.occupied) begin
					$display("%0t: occupied exp %b got %b", $time, want.occupied, got.occupied);
					errors++;
				end
				if (got.changed !== want.changed) begin
					$display("%0t: changed exp %b got %b", $time, want.changed, got.changed);
					errors++;
				end
			end
		end
	end

	// stall watchdog; the clearing pass after reset fits well inside the limit
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		m_free_valid = 1'b0;
		m_free_head  = 0;
		m_slots_used = 0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_free_list();
		test_backpressure();
		test_random(120);
		drain_cells();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
